// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the pulse segment selector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, suspended while reset is high
`define PSEL_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define PSEL_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/psel_pkg.sv -----
// ----------------------------------------------------------------------------
// psel_pkg
// Types, widths and codes of the pulse segment selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psel_pkg;

   parameter int MAX_ONSETS_DEF = 256;
   parameter int MAX_PULSES_DEF = 32;

   parameter int TRIG_W     = 15;
   parameter int LEN_W      = 12;
   parameter int TAIL_W     = 7;
   parameter int PCNT_W     = 6;
   parameter int STATUS_W   = 2;
   parameter int CSR_IDX_W  = 2;
   parameter int CSR_DATA_W = 12;

   parameter logic [CSR_IDX_W-1:0] CSR_TAIL    = 2'd0;
   parameter logic [CSR_IDX_W-1:0] CSR_MIN_LEN = 2'd1;
   parameter logic [CSR_IDX_W-1:0] CSR_MAX_LEN = 2'd2;

   parameter logic [TAIL_W-1:0] TAIL_RESET    = 7'd0;
   parameter logic [LEN_W-1:0]  MIN_LEN_RESET = 12'd39;
   parameter logic [LEN_W-1:0]  MAX_LEN_RESET = 12'd256;

   parameter logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   parameter logic [STATUS_W-1:0] STATUS_FEW_ONSETS  = 2'd1;
   parameter logic [STATUS_W-1:0] STATUS_NO_AVERAGE  = 2'd2;
   parameter logic [STATUS_W-1:0] STATUS_FEW_PULSES  = 2'd3;

   typedef struct packed {
      logic [TRIG_W-1:0] trigger_point;
      logic              last_trigger;
   } req_payload_type;

   typedef struct packed {
      logic                is_summary;
      logic [TRIG_W-1:0]   onset_index;
      logic [TRIG_W-1:0]   signal_offset;
      logic [LEN_W-1:0]    pulse_length;
      logic [PCNT_W-1:0]   pulse_count;
      logic [STATUS_W-1:0] status;
      logic                last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic                wr_trigger;
      logic                clr_acc;
      logic                clr_walk;
      logic                take_prev;
      logic                idx_inc;
      logic                step_sum;
      logic                latch_len;
      logic                mul;
      logic                emit_pulse;
      logic                emit_summary;
      logic [STATUS_W-1:0] status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic few_onsets;
      logic walk_end;
      logic no_len;
      logic acc_full;
      logic multi_acc;
      logic pulse_ok;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/psel_ram.sv -----
// ----------------------------------------------------------------------------
// psel_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psel_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/psel_dp.sv -----
// ----------------------------------------------------------------------------
// psel_dp
// Datapath: trigger store, length sum and count, average window test,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psel_dp import psel_pkg::*; #(
   parameter int MAX_ONSETS = MAX_ONSETS_DEF,
   parameter int MAX_PULSES = MAX_PULSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         stat,
   input  logic [TRIG_W-1:0]     trigger_point,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data
);

   localparam int AW = $clog2(MAX_ONSETS);
   localparam int CW = $clog2(MAX_ONSETS + 1);
   localparam int SW = LEN_W + AW;
   localparam int PW = LEN_W + CW;
   localparam int XW = PW + 3;
   localparam int LW = TRIG_W + 2;

   logic [TAIL_W-1:0]   tail_ff, tail_in;
   logic [LEN_W-1:0]    min_ff, min_in;
   logic [LEN_W-1:0]    max_ff, max_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [TRIG_W-1:0]   prev_ff, prev_in;
   logic [TRIG_W-1:0]   t0_ff, t0_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [PCNT_W-1:0]   acc_ff, acc_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                rng_ff, rng_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic [TRIG_W-1:0]   rd_data;
   logic                store_wr;
   logic signed [LW-1:0] len_w;
   logic signed [LW-1:0] min_s;
   logic signed [LW-1:0] max_s;
   logic [XW-1:0]       sum3;
   logic [XW-1:0]       prod5;
   logic [XW-1:0]       prod2;
   logic [TRIG_W-1:0]   tail_ext;
   logic                out_free;

   assign store_wr = cmd.wr_trigger && (cnt_ff < CW'(MAX_ONSETS));

   psel_ram #(
      .WIDTH(TRIG_W),
      .DEPTH(MAX_ONSETS)
   ) u_store (
      .clock  (clock),
      .wr_en  (store_wr),
      .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(trigger_point),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign len_w = $signed({2'b00, rd_data}) - $signed({2'b00, prev_ff}) + $signed(LW'(1));
   assign min_s = $signed({{(LW - LEN_W){1'b0}}, min_ff});
   assign max_s = $signed({{(LW - LEN_W){1'b0}}, max_ff});

   assign sum3     = (XW'(sum_ff) << 1) + XW'(sum_ff);
   assign prod5    = (XW'(prod_ff) << 2) + XW'(prod_ff);
   assign prod2    = XW'(prod_ff) << 1;
   assign tail_ext = TRIG_W'(tail_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      tail_in = tail_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TAIL:    tail_in = csr_data[TAIL_W-1:0];
            CSR_MIN_LEN: min_in  = csr_data[LEN_W-1:0];
            CSR_MAX_LEN: max_in  = csr_data[LEN_W-1:0];
            default:     tail_in = tail_ff;
         endcase
      end
   end

   always_comb begin
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      t0_in        = t0_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      rng_in       = rng_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (store_wr) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.clr_acc) begin
         acc_in = '0;
         sum_in = '0;
         n_in   = '0;
      end
      if (cmd.clr_walk) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.take_prev) begin
         prev_in = rd_data;
      end
      if (cmd.step_sum && (len_w > min_s) && (len_w < max_s)) begin
         sum_in = sum_ff + SW'(len_w[LEN_W-1:0]);
         n_in   = n_ff + CW'(1);
      end
      if (cmd.latch_len) begin
         len_in = len_w[LEN_W-1:0];
         rng_in = (len_w >= min_s) && (len_w <= max_s);
         t0_in  = prev_ff;
      end
      if (cmd.mul) begin
         prod_in = PW'(len_ff) * PW'(n_ff);
      end
      if (cmd.emit_pulse) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.is_summary    = 1'b0;
         rsp_data_in.onset_index   = t0_ff;
         rsp_data_in.signal_offset = t0_ff - tail_ext;
         rsp_data_in.pulse_length  = len_ff;
         rsp_data_in.pulse_count   = '0;
         rsp_data_in.status        = STATUS_OK;
         rsp_data_in.last_result   = 1'b0;
         acc_in                    = acc_ff + PCNT_W'(1);
      end
      if (cmd.emit_summary) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.is_summary    = 1'b1;
         rsp_data_in.onset_index   = '0;
         rsp_data_in.signal_offset = '0;
         rsp_data_in.pulse_length  = '0;
         rsp_data_in.pulse_count   = acc_ff;
         rsp_data_in.status        = cmd.status;
         rsp_data_in.last_result   = 1'b1;
         cnt_in                    = '0;
         sum_in                    = '0;
         n_in                      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff      <= TAIL_RESET;
         min_ff       <= MIN_LEN_RESET;
         max_ff       <= MAX_LEN_RESET;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         n_ff         <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tail_ff      <= tail_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         n_ff         <= n_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      t0_ff       <= t0_in;
      len_ff      <= len_in;
      rng_ff      <= rng_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.few_onsets = cnt_ff <= CW'(1);
   assign stat.walk_end   = CW'(idx_ff) == (cnt_ff - CW'(1));
   assign stat.no_len     = n_ff == '0;
   assign stat.acc_full   = acc_ff >= PCNT_W'(MAX_PULSES);
   assign stat.multi_acc  = acc_ff > PCNT_W'(1);
   assign stat.pulse_ok   = rng_ff && (prod5 >= sum3) && (prod2 <= sum3) && (t0_ff >= tail_ext);
   assign stat.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/psel_ctrl.sv -----
// ----------------------------------------------------------------------------
// psel_ctrl
// Controller: loads triggers, then runs the sum pass, the selection pass
// and the summary over the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psel_ctrl import psel_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   output logic          req_stall,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_START   = 4'd1;
   localparam logic [3:0] S_LOAD0   = 4'd2;
   localparam logic [3:0] S_FIRST   = 4'd3;
   localparam logic [3:0] S_READ    = 4'd4;
   localparam logic [3:0] S_DATA    = 4'd5;
   localparam logic [3:0] S_TURN    = 4'd6;
   localparam logic [3:0] S_MUL     = 4'd7;
   localparam logic [3:0] S_CHK     = 4'd8;
   localparam logic [3:0] S_SUMMARY = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic                pass_ff, pass_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      status_in = status_ff;
      req_stall = 1'b1;
      cmd       = '0;
      if (status_ff == STATUS_OK) begin
         cmd.status = stat.multi_acc ? STATUS_OK : STATUS_FEW_PULSES;
      end else begin
         cmd.status = status_ff;
      end

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.wr_trigger = 1'b1;
               if (req_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.clr_acc  = 1'b1;
            cmd.clr_walk = 1'b1;
            pass_in      = 1'b0;
            if (stat.few_onsets) begin
               status_in = STATUS_FEW_ONSETS;
               state_in  = S_SUMMARY;
            end else begin
               state_in = S_LOAD0;
            end
         end
         S_LOAD0: begin
            state_in = S_FIRST;
         end
         S_FIRST: begin
            cmd.take_prev = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            cmd.take_prev = 1'b1;
            if (!pass_ff) begin
               cmd.step_sum = 1'b1;
               if (stat.walk_end) begin
                  state_in = S_TURN;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end else if (stat.acc_full) begin
               status_in = STATUS_OK;
               state_in  = S_SUMMARY;
            end else begin
               cmd.latch_len = 1'b1;
               state_in      = S_MUL;
            end
         end
         S_TURN: begin
            if (stat.no_len) begin
               status_in = STATUS_NO_AVERAGE;
               state_in  = S_SUMMARY;
            end else begin
               pass_in      = 1'b1;
               cmd.clr_walk = 1'b1;
               state_in     = S_LOAD0;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!stat.pulse_ok || stat.out_free) begin
               cmd.emit_pulse = stat.pulse_ok;
               if (stat.walk_end) begin
                  status_in = STATUS_OK;
                  state_in  = S_SUMMARY;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_SUMMARY: begin
            if (stat.out_free) begin
               cmd.emit_summary = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pass_ff   <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         pass_ff   <= pass_in;
         status_ff <= status_in;
      end
   end

endmodule

// ----- rtl/pulse_segment_selector.sv -----
// ----------------------------------------------------------------------------
// pulse_segment_selector
// Collects ascending trigger points, then selects the pulses whose length
// lies within the limits and within 60% to 150% of the average length.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  req_payload_type
//   rsp_     out        rsp_valid / rsp_stall  rsp_payload_type
//   csr_     in         csr_valid / csr_ready  csr_index, csr_data
//
// A trigger that does not end the set is taken while the block is idle.
// After the final trigger, the single read port of the trigger store is
// walked once to sum lengths (read, data) and once to test them (read,
// data, multiply, compare).
// Fewer than two triggers go straight to the summary, as does a set with no
// length for the average; reaching the pulse limit ends the test walk early.
// Reset is synchronous and clears counters, limits and the result valid flag.
// A stalled result holds the walk when a pulse is to be sent; the next set is
// taken after the summary.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pulse_segment_selector import psel_pkg::*; #(
   parameter int MAX_ONSETS = MAX_ONSETS_DEF,
   parameter int MAX_PULSES = MAX_PULSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   logic last_accept;
   logic summary_out;
   logic pulse_out;
   logic count_ok;
   logic offset_ok;

   assign csr_ready = 1'b1;

   psel_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_last (req_data.last_trigger),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   psel_dp #(
      .MAX_ONSETS(MAX_ONSETS),
      .MAX_PULSES(MAX_PULSES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .trigger_point(req_data.trigger_point),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   assign last_accept = req_valid && !req_stall && req_data.last_trigger;
   assign summary_out = rsp_valid && rsp_data.is_summary;
   assign pulse_out   = rsp_valid && !rsp_data.is_summary;
   assign count_ok    = rsp_data.pulse_count <= PCNT_W'(MAX_PULSES);
   assign offset_ok   = rsp_data.signal_offset <= rsp_data.onset_index;

   `PSEL_ASSERT_RST(a_stall_after_last, clock, reset, last_accept |=> req_stall, "open after last")
   `PSEL_ASSERT_RST(a_count_limit, clock, reset, summary_out |-> count_ok, "count over limit")
   `PSEL_ASSERT_RST(a_offset_order, clock, reset, pulse_out |-> offset_ok, "offset beyond onset")

endmodule

// ----- verif/pulse_segment_selector_tb.sv -----
// ----------------------------------------------------------------------------
// pulse_segment_selector_tb
// Drives sets of trigger points through the pulse segment selector under
// several limit and tail settings and random idling on both channels. A
// scoreboard predicts the pulse and summary records of each set and checks
// every record the block returns, in order and field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_segment_selector_tb;
   import psel_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 17;

   localparam int PH_TAIL [NUM_PHASES] = '{20, 0, 127, 0, 64, 5, 33, 0};
   localparam int PH_MIN  [NUM_PHASES] = '{39, 39, 1, 4095, 100, 20, 200, 50};
   localparam int PH_MAX  [NUM_PHASES] = '{256, 256, 4095, 1, 300, 60, 4095, 150};
   localparam int PH_TX   [NUM_PHASES] = '{0, 49, 0, 17, 0, 49, 0, 17};
   localparam int PH_RX   [NUM_PHASES] = '{0, 0, 49, 17, 0, 0, 49, 17};

   class pulse_scoreboard;
      logic [TRIG_W-1:0] onsets [MAX_ONSETS_DEF];
      int                num_onsets;
      logic [TAIL_W-1:0] tail;
      logic [LEN_W-1:0]  min_len;
      logic [LEN_W-1:0]  max_len;
      rsp_payload_type   expected_records [$];
      int                errors;

      function new();
         num_onsets = 0;
         tail       = TAIL_RESET;
         min_len    = MIN_LEN_RESET;
         max_len    = MAX_LEN_RESET;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_TAIL:    tail    = val[TAIL_W-1:0];
            CSR_MIN_LEN: min_len = val[LEN_W-1:0];
            CSR_MAX_LEN: max_len = val[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_trigger(req_payload_type item);
         int              len;
         int              offs;
         int              sum;
         int              cnt;
         int              kept;
         logic [STATUS_W-1:0] stat;
         rsp_payload_type rec;
         if (num_onsets < MAX_ONSETS_DEF) begin
            onsets[num_onsets] = item.trigger_point;
            num_onsets++;
         end
         if (!item.last_trigger) return;
         kept = 0;
         if (num_onsets <= 1) begin
            stat = STATUS_FEW_ONSETS;
         end else begin
            sum = 0;
            cnt = 0;
            for (int i = 0; i + 1 < num_onsets; i++) begin
               len = int'(onsets[i+1]) - int'(onsets[i]) + 1;
               if (len < int'(max_len) && len > int'(min_len)) begin
                  sum += len;
                  cnt++;
               end
            end
            if (cnt == 0) begin
               stat = STATUS_NO_AVERAGE;
            end else begin
               for (int i = 0; i + 1 < num_onsets; i++) begin
                  if (kept >= MAX_PULSES_DEF) break;
                  len = int'(onsets[i+1]) - int'(onsets[i]) + 1;
                  if (len > int'(max_len) || len < int'(min_len)) continue;
                  if (!(5 * len * cnt >= 3 * sum && 2 * len * cnt <= 3 * sum)) continue;
                  offs = int'(onsets[i]) - int'(tail);
                  if (offs < 0) continue;
                  rec               = '0;
                  rec.onset_index   = onsets[i];
                  rec.signal_offset = offs[TRIG_W-1:0];
                  rec.pulse_length  = len[LEN_W-1:0];
                  expected_records.push_back(rec);
                  kept++;
               end
               stat = (kept > 1) ? STATUS_OK : STATUS_FEW_PULSES;
            end
         end
         rec             = '0;
         rec.is_summary  = 1'b1;
         rec.pulse_count = kept[PCNT_W-1:0];
         rec.status      = stat;
         rec.last_result = 1'b1;
         expected_records.push_back(rec);
         num_onsets = 0;
      endfunction

      function void check_record(rsp_payload_type got);
         rsp_payload_type exp;
         bit              same;
         if (expected_records.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected record: summ=%0d onset=%0d offs=%0d len=%0d cnt=%0d st=%0d last=%0d",
                        got.is_summary, got.onset_index, got.signal_offset, got.pulse_length,
                        got.pulse_count, got.status, got.last_result);
            return;
         end
         exp  = expected_records.pop_front();
         same = (got.is_summary === exp.is_summary) &&
                (got.onset_index === exp.onset_index) &&
                (got.signal_offset === exp.signal_offset) &&
                (got.pulse_length === exp.pulse_length) &&
                (got.pulse_count === exp.pulse_count) &&
                (got.status === exp.status) &&
                (got.last_result === exp.last_result);
         if (!same) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch expected: summ=%0d onset=%0d offs=%0d len=%0d cnt=%0d st=%0d last=%0d",
                        exp.is_summary, exp.onset_index, exp.signal_offset, exp.pulse_length,
                        exp.pulse_count, exp.status, exp.last_result);
               $display("         actual:   summ=%0d onset=%0d offs=%0d len=%0d cnt=%0d st=%0d last=%0d",
                        got.is_summary, got.onset_index, got.signal_offset, got.pulse_length,
                        got.pulse_count, got.status, got.last_result);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   pulse_scoreboard sb = new();

   int tx_pct;
   int rx_pct;
   bit hold_request;
   int cfg_min;
   int cfg_max;

   pulse_segment_selector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout waiting for records");
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = (rx_pct != 0) && ($urandom_range(99) < rx_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_record(rsp_data);
   end

   task automatic write_regs(input int tail_val, input int min_val, input int max_val);
      logic [CSR_IDX_W-1:0]  idx [3];
      logic [CSR_DATA_W-1:0] val [3];
      idx = '{CSR_TAIL, CSR_MIN_LEN, CSR_MAX_LEN};
      val = '{CSR_DATA_W'(tail_val), CSR_DATA_W'(min_val), CSR_DATA_W'(max_val)};
      for (int k = 0; k < 3; k++) begin
         csr_valid = 1'b1;
         csr_index = idx[k];
         csr_data  = val[k];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(idx[k], val[k]);
         @(negedge clock);
      end
      csr_valid = 1'b0;
      cfg_min   = min_val;
      cfg_max   = max_val;
   endtask

   task automatic send_trigger(input int tp, input bit fin);
      while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = '{trigger_point: TRIG_W'(tp), last_trigger: fin};
      do @(posedge clock); while (req_stall);
      sb.note_trigger(req_data);
      @(negedge clock);
   endtask

   task automatic send_set(input int pts [$]);
      foreach (pts[k])
         send_trigger(pts[k], k == pts.size() - 1);
   endtask

   // build one set around a nominal pulse length, with outliers or noise
   task automatic random_set(input int n_trig, input bit noise);
      int pts [$];
      int lens [$];
      int nominal;
      int cap;
      int ln;
      int span;
      int t;
      if (noise) begin
         for (int k = 0; k < n_trig; k++) pts.push_back($urandom_range(32767));
         send_set(pts);
         return;
      end
      if (cfg_max > cfg_min + 2) nominal = $urandom_range(cfg_max - 1, cfg_min + 1);
      else nominal = $urandom_range(400, 2);
      cap = 32000 / n_trig;
      if (nominal > cap) nominal = cap;
      if (nominal < 2) nominal = 2;
      span = 0;
      for (int k = 1; k < n_trig; k++) begin
         ln = nominal + $urandom_range(nominal / 4) - nominal / 8;
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
               0: ln = nominal * 2;
               1: ln = nominal / 2;
               2: ln = $urandom_range(4095);
               default: ln = -$urandom_range(200);
            endcase
         end
         lens.push_back(ln);
         if (ln > 1) span += ln - 1;
      end
      t = (span < 32767) ? $urandom_range(32767 - span) : 0;
      pts.push_back(t);
      foreach (lens[k]) begin
         t += lens[k] - 1;
         if (t < 0) t = 0;
         if (t > 32767) t = 32767;
         pts.push_back(t);
      end
      send_set(pts);
   endtask

   task automatic drain_phase();
      req_valid = 1'b0;
      while (sb.expected_records.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int sent;
      int n;
      int roll;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_TAIL;
      csr_data     = '0;
      tx_pct       = 0;
      rx_pct       = 0;
      hold_request = 1'b0;
      cfg_min      = MIN_LEN_RESET;
      cfg_max      = MAX_LEN_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_regs(PH_TAIL[0], PH_MIN[0], PH_MAX[0]);
      send_set('{32767});
      send_set('{0, 10});
      send_set('{5, 105, 205, 305});
      send_set('{2000, 1900, 1800});
      send_set('{100, 200});
      send_set('{1000, 1100, 1200, 1400, 1450, 1550});
      send_set('{32000, 32100, 32767});
      send_set('{4000, 4038, 4138, 4238});
      drain_phase();

      for (int p = 1; p < NUM_PHASES; p++) begin
         tx_pct = PH_TX[p];
         rx_pct = PH_RX[p];
         write_regs(PH_TAIL[p], PH_MIN[p], PH_MAX[p]);
         if (p == 2 || p == 6) hold_request = 1'b1;
         if (p == 1) random_set(MAX_ONSETS_DEF + 2, 1'b0);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 10) n = $urandom_range(40, 34);
            else if (roll < 80) n = $urandom_range(14, 2);
            else if (roll < 90) n = 1;
            else n = $urandom_range(8, 2);
            random_set(n, roll >= 90);
            sent += n;
         end
         drain_phase();
      end

      if (sb.errors == 0 && sb.expected_records.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/psel_pkg.sv
rtl/psel_ram.sv
rtl/psel_dp.sv
rtl/psel_ctrl.sv
rtl/pulse_segment_selector.sv
verif/pulse_segment_selector_tb.sv
